### hdl/bfrd_pkg.sv
// Shared types, constants and the luma function for the black frame run detector.
`default_nettype none

package bfrd_pkg;

    localparam int unsigned PIX_W       = 8;
    localparam int unsigned LUMA_W      = 8;
    localparam int unsigned SUM_W       = 32;
    localparam int unsigned THR_W       = 16;
    localparam int unsigned OUT_IDX_W   = 24;
    localparam int unsigned LUMA_ACC_W  = 23;
    localparam int unsigned LUMA_SHIFT  = 14;

    localparam logic [THR_W-1:0] THRESHOLD_RESET = 16'd1280;   // 5.0 in Q8.8

    localparam int unsigned DEF_MAX_PIXELS       = 16777216;
    localparam int unsigned DEF_FRAME_INDEX_BITS = 24;

    // Integer luma weights (Q14) and rounding term
    localparam logic [LUMA_ACC_W-1:0] W_BLUE  = 23'd1868;
    localparam logic [LUMA_ACC_W-1:0] W_GREEN = 23'd9617;
    localparam logic [LUMA_ACC_W-1:0] W_RED   = 23'd4899;
    localparam logic [LUMA_ACC_W-1:0] W_ROUND = 23'd8192;

    typedef enum logic [0:0] {
        CMD_PIXEL = 1'b0,
        CMD_FLUSH = 1'b1
    } cmd_t;

    // One item after the luma stage
    typedef struct packed {
        cmd_t              cmd;
        logic              frame_end;
        logic [LUMA_W-1:0] luma;
    } pix_item_t;

    function automatic logic [LUMA_W-1:0] luma_of(
        input logic [PIX_W-1:0] b,
        input logic [PIX_W-1:0] g,
        input logic [PIX_W-1:0] r
    );
        logic [LUMA_ACC_W-1:0] acc;
        acc = W_BLUE * LUMA_ACC_W'(b) + W_GREEN * LUMA_ACC_W'(g)
            + W_RED * LUMA_ACC_W'(r) + W_ROUND;
        return acc[LUMA_SHIFT +: LUMA_W];
    endfunction

endpackage

`default_nettype wire

### hdl/bfrd_frame_stats.sv
// Per-frame luma sum and pixel count; hands one summary per frame end or flush.
`default_nettype none

module bfrd_frame_stats #(
    parameter int unsigned MAX_PIXELS_PER_FRAME = bfrd_pkg::DEF_MAX_PIXELS,
    parameter int unsigned CNT_W                = $clog2(MAX_PIXELS_PER_FRAME + 1)
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire bfrd_pkg::pix_item_t         in_item,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output bfrd_pkg::cmd_t                   out_cmd,
    output logic [bfrd_pkg::SUM_W-1:0]       out_sum,
    output logic [CNT_W-1:0]                 out_count
);

    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PIXELS_PER_FRAME);

    logic [bfrd_pkg::SUM_W-1:0] sum_reg, sum_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic                       vld_reg, vld_next;
    bfrd_pkg::cmd_t             cmd_reg, cmd_next;
    logic [bfrd_pkg::SUM_W-1:0] osum_reg, osum_next;
    logic [CNT_W-1:0]           ocnt_reg, ocnt_next;

    logic                       passes;    // item yields a summary
    logic                       slot_free;
    logic                       consume;
    logic [bfrd_pkg::SUM_W-1:0] sum_add;
    logic [CNT_W-1:0]           cnt_add;

    assign slot_free = !vld_reg || out_ready;
    assign passes    = (in_item.cmd == bfrd_pkg::CMD_FLUSH) || in_item.frame_end;
    assign consume   = in_valid && (!passes || slot_free);
    assign in_ready  = !passes || slot_free;

    always_comb begin
        if (cnt_reg < CNT_MAX) begin
            sum_add = sum_reg + bfrd_pkg::SUM_W'(in_item.luma);
            cnt_add = cnt_reg + CNT_W'(1);
        end else begin
            sum_add = sum_reg;
            cnt_add = cnt_reg;
        end
    end

    always_comb begin
        sum_next  = sum_reg;
        cnt_next  = cnt_reg;
        vld_next  = vld_reg && !out_ready;
        cmd_next  = cmd_reg;
        osum_next = osum_reg;
        ocnt_next = ocnt_reg;
        if (consume) begin
            if (in_item.cmd == bfrd_pkg::CMD_FLUSH) begin
                // partial frame dropped
                sum_next = '0;
                cnt_next = '0;
                vld_next = 1'b1;
                cmd_next = bfrd_pkg::CMD_FLUSH;
            end else if (in_item.frame_end) begin
                sum_next  = '0;
                cnt_next  = '0;
                vld_next  = 1'b1;
                cmd_next  = bfrd_pkg::CMD_PIXEL;
                osum_next = sum_add;
                ocnt_next = cnt_add;
            end else begin
                sum_next = sum_add;
                cnt_next = cnt_add;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg <= '0;
            cnt_reg <= '0;
            vld_reg <= 1'b0;
            cmd_reg <= bfrd_pkg::CMD_PIXEL;
        end else begin
            sum_reg <= sum_next;
            cnt_reg <= cnt_next;
            vld_reg <= vld_next;
            cmd_reg <= cmd_next;
        end
    end

    always_ff @(posedge aclk) begin
        osum_reg <= osum_next;
        ocnt_reg <= ocnt_next;
    end

    assign out_valid = vld_reg;
    assign out_cmd   = cmd_reg;
    assign out_sum   = osum_reg;
    assign out_count = ocnt_reg;

endmodule

`default_nettype wire

### hdl/black_frame_run_detector.sv
// Top level: luma stage, frame statistics, threshold product and run tracking.
//
//  Channel  | Dir | Handshake          | Payload
//  ---------+-----+--------------------+-----------------------------------------------
//  s_       | in  | s_tvalid/s_tready  | tdata blue,green,red; tuser command; tlast end
//  m_       | out | m_tvalid/m_tready  | tdata start_frame, end_frame
//  cfg_     | in  | cfg_wr_en          | cfg_wr_data threshold_q8 (Q8.8)
//
// One item per clock sustained while m_tready does not hold back a result. m_tvalid
// rises once the item that closes a run has passed the input reg, luma reg, frame
// summary reg, threshold product reg and result reg.
// Every stage holds its own valid bit; a stage advances when the one below is
// empty or moving, so bubbles fill while a result waits on m_tready.
// Synchronous active-low reset clears valids, accumulators, run state and sets
// the threshold to 5.0.
`default_nettype none

module black_frame_run_detector #(
    parameter int unsigned MAX_PIXELS_PER_FRAME = bfrd_pkg::DEF_MAX_PIXELS,
    parameter int unsigned FRAME_INDEX_BITS     = bfrd_pkg::DEF_FRAME_INDEX_BITS
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // item in
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [23:0]                   s_tdata,   // [7:0] blue, [15:8] green, [23:16] red
    input  wire logic [0:0]                    s_tuser,   // [0] command (0 pixel, 1 flush)
    input  wire logic                          s_tlast,   // frame_end
    // run result out
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [47:0]                        m_tdata,   // [23:0] start_frame, [47:24] end_frame
    // threshold register
    input  wire logic                          cfg_wr_en,
    input  wire logic [bfrd_pkg::THR_W-1:0]    cfg_wr_data
);

    localparam int unsigned CNT_W  = $clog2(MAX_PIXELS_PER_FRAME + 1);
    localparam int unsigned PROD_W = bfrd_pkg::THR_W + CNT_W;
    localparam int unsigned SHL_W  = bfrd_pkg::SUM_W + 8;
    localparam int unsigned CMP_W  = (PROD_W > SHL_W) ? PROD_W : SHL_W;
    localparam int unsigned OW     = bfrd_pkg::OUT_IDX_W;

    // ---------------- threshold register ----------------
    logic [bfrd_pkg::THR_W-1:0] thr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= bfrd_pkg::THRESHOLD_RESET;
        end else if (cfg_wr_en) begin
            thr_reg <= cfg_wr_data;
        end
    end

    // ---------------- handshake chain ----------------
    logic in_vld_reg, luma_vld_reg, prod_vld_reg, m_vld_reg;
    logic adv_in, adv_luma, adv_prod;
    logic stats_ready, stats_valid;
    logic out_free, emit, consume_prod;

    assign out_free     = !m_vld_reg || m_tready;
    assign consume_prod = prod_vld_reg && (!emit || out_free);
    assign adv_prod     = !prod_vld_reg || consume_prod;          // product stage loads
    assign adv_luma     = !luma_vld_reg || stats_ready;           // luma stage loads
    assign adv_in       = !in_vld_reg || adv_luma;                // input stage loads
    assign s_tready     = adv_in;

    // ---------------- input register ----------------
    logic [7:0]      blue_reg, green_reg, red_reg;
    bfrd_pkg::cmd_t  in_cmd_reg;
    logic            in_end_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (adv_in) begin
            in_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv_in) begin
            blue_reg   <= s_tdata[7:0];
            green_reg  <= s_tdata[15:8];
            red_reg    <= s_tdata[23:16];
            in_cmd_reg <= bfrd_pkg::cmd_t'(s_tuser);
            in_end_reg <= s_tlast;
        end
    end

    // ---------------- luma stage ----------------
    bfrd_pkg::pix_item_t luma_item_reg, luma_item_next;

    always_comb begin
        luma_item_next.cmd       = in_cmd_reg;
        luma_item_next.frame_end = in_end_reg;
        luma_item_next.luma      = bfrd_pkg::luma_of(blue_reg, green_reg, red_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            luma_vld_reg <= 1'b0;
        end else if (adv_luma) begin
            luma_vld_reg <= in_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv_luma) begin
            luma_item_reg <= luma_item_next;
        end
    end

    // ---------------- frame sum / count ----------------
    bfrd_pkg::cmd_t              st_cmd;
    logic [bfrd_pkg::SUM_W-1:0]  st_sum;
    logic [CNT_W-1:0]            st_cnt;

    bfrd_frame_stats #(
        .MAX_PIXELS_PER_FRAME (MAX_PIXELS_PER_FRAME),
        .CNT_W                (CNT_W)
    ) u_stats (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (luma_vld_reg),
        .in_ready  (stats_ready),
        .in_item   (luma_item_reg),
        .out_valid (stats_valid),
        .out_ready (adv_prod),
        .out_cmd   (st_cmd),
        .out_sum   (st_sum),
        .out_count (st_cnt)
    );

    // ---------------- threshold * count ----------------
    logic [PROD_W-1:0]           prod_reg;
    logic [bfrd_pkg::SUM_W-1:0]  psum_reg;
    bfrd_pkg::cmd_t              pcmd_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_vld_reg <= 1'b0;
        end else if (adv_prod) begin
            prod_vld_reg <= stats_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv_prod) begin
            prod_reg <= PROD_W'(thr_reg) * PROD_W'(st_cnt);
            psum_reg <= st_sum;
            pcmd_reg <= st_cmd;
        end
    end

    // ---------------- black decision and run tracking ----------------
    logic [FRAME_INDEX_BITS-1:0] frame_idx_reg, frame_idx_next;
    logic [FRAME_INDEX_BITS-1:0] run_first_reg, run_first_next;
    logic [FRAME_INDEX_BITS-1:0] run_last_reg, run_last_next;
    logic                        run_open_reg, run_open_next;
    logic                        black;
    logic [FRAME_INDEX_BITS-1:0] idx_inc;

    // mean < threshold  <=>  sum*256 < threshold*count
    assign black   = CMP_W'({psum_reg, 8'd0}) < CMP_W'(prod_reg);
    assign idx_inc = (frame_idx_reg != '1) ? frame_idx_reg + FRAME_INDEX_BITS'(1)
                                           : frame_idx_reg;

    always_comb begin
        if (pcmd_reg == bfrd_pkg::CMD_FLUSH) begin
            emit = run_open_reg;
        end else begin
            emit = run_open_reg && !black;
        end
    end

    always_comb begin
        frame_idx_next = frame_idx_reg;
        run_first_next = run_first_reg;
        run_last_next  = run_last_reg;
        run_open_next  = run_open_reg;
        if (consume_prod) begin
            if (pcmd_reg == bfrd_pkg::CMD_FLUSH) begin
                // next video restarts at frame 0
                run_open_next  = 1'b0;
                frame_idx_next = '0;
            end else begin
                if (black) begin
                    if (!run_open_reg) begin
                        run_first_next = frame_idx_reg;
                    end
                    run_open_next = 1'b1;
                    run_last_next = frame_idx_reg;
                end else begin
                    run_open_next = 1'b0;
                end
                frame_idx_next = idx_inc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_idx_reg <= '0;
            run_open_reg  <= 1'b0;
        end else begin
            frame_idx_reg <= frame_idx_next;
            run_open_reg  <= run_open_next;
        end
    end

    always_ff @(posedge aclk) begin
        run_first_reg <= run_first_next;
        run_last_reg  <= run_last_next;
    end

    // ---------------- result register ----------------
    logic [47:0] m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_vld_reg <= 1'b0;
        end else if (consume_prod && emit) begin
            m_vld_reg <= 1'b1;
        end else if (m_tready) begin
            m_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (consume_prod && emit) begin
            m_data_reg <= {OW'(run_last_reg), OW'(run_first_reg)};
        end
    end

    assign m_tvalid = m_vld_reg;
    assign m_tdata  = m_data_reg;

`ifndef SYNTHESIS
    // a new result only appears when a run was open
    a_emit_needs_run: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_vld_reg) |-> $past(run_open_reg))
        else $error("result issued without an open run");

    // an open run never starts after it ends
    a_run_order: assert property (@(posedge aclk) disable iff (!aresetn)
        run_open_reg |-> (run_first_reg <= run_last_reg))
        else $error("run first index beyond last index");

    // a flush leaves no run open and restarts the frame count
    a_flush_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (consume_prod && pcmd_reg == bfrd_pkg::CMD_FLUSH)
        |=> (!run_open_reg && frame_idx_reg == '0))
        else $error("flush did not clear run state");

    // a held result is never overwritten
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_vld_reg && !m_tready) |-> !(consume_prod && emit))
        else $error("pending result overwritten");
`endif

endmodule

`default_nettype wire

### tb/sv/black_frame_run_detector_test.sv
// Self-checking testbench for the black frame run detector: directed frames, then random video.
`timescale 1ns / 1ps

module black_frame_run_detector_test;

    localparam int CLK_HALF     = 5;
    localparam int IDLE_PCT     = 9;        // chance per cycle that a side takes a break
    localparam int DRAIN_CYCLES = 12;       // 5-stage pipe plus margin
    localparam int CYCLE_LIMIT  = 200000;

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata     = '0;          // [7:0] blue, [15:8] green, [23:16] red
    logic [0:0]  s_tuser     = '0;          // [0] command
    logic        s_tlast     = 1'b0;        // frame_end
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [47:0] m_tdata;                   // [23:0] start_frame, [47:24] end_frame
    logic        cfg_wr_en   = 1'b0;
    logic [bfrd_pkg::THR_W-1:0] cfg_wr_data = '0;

    bit steady = 1'b0;                      // when set, neither side takes breaks
    int cycle_count = 0;
    int threshold_writes = 0;

    // Tracks luma statistics and black runs, queues the run each item closes.
    class run_scoreboard;
        typedef struct packed {
            logic [23:0] start_frame;
            logic [23:0] end_frame;
        } run_t;

        localparam int unsigned Y_BLUE  = 1868;
        localparam int unsigned Y_GREEN = 9617;
        localparam int unsigned Y_RED   = 4899;
        localparam int unsigned Y_HALF  = 8192;
        localparam int unsigned FRAME_PIXEL_CAP = 16777216;

        logic [15:0] threshold;
        logic [31:0] luma_sum;
        logic [24:0] pixel_count;
        logic [23:0] frame_index;
        bit          run_open;
        logic [23:0] run_first;
        logic [23:0] run_last;
        run_t        expected_runs[$];
        int          mismatches;
        int          items_seen;
        int          runs_seen;

        function new();
            threshold   = 16'd1280;
            luma_sum    = '0;
            pixel_count = '0;
            frame_index = '0;
            run_open    = 1'b0;
            run_first   = '0;
            run_last    = '0;
            mismatches  = 0;
            items_seen  = 0;
            runs_seen   = 0;
        endfunction

        function void set_threshold(logic [15:0] value);
            threshold = value;
        endfunction

        function int pending();
            return expected_runs.size();
        endfunction

        function logic [7:0] luma(logic [7:0] b, logic [7:0] g, logic [7:0] r);
            int unsigned acc;
            acc = Y_BLUE * b + Y_GREEN * g + Y_RED * r + Y_HALF;
            return acc[21:14];
        endfunction

        function void close_run();
            run_t run;
            run.start_frame = run_first;
            run.end_frame   = run_last;
            expected_runs   = {expected_runs, run};
            run_open = 1'b0;
        endfunction

        function void note_input(bfrd_pkg::cmd_t cmd, logic [7:0] b, logic [7:0] g,
                                 logic [7:0] r, logic last);
            longint unsigned scaled_sum;
            longint unsigned bound;
            items_seen++;
            if (cmd == bfrd_pkg::CMD_FLUSH) begin
                // end of video: emit any open run, drop the partial frame, restart indexing
                if (run_open)
                    close_run();
                luma_sum    = '0;
                pixel_count = '0;
                frame_index = '0;
                return;
            end
            if (pixel_count < FRAME_PIXEL_CAP) begin
                luma_sum    = luma_sum + luma(b, g, r);
                pixel_count = pixel_count + 1'b1;
            end
            if (!last)
                return;
            scaled_sum = longint'(luma_sum) << 8;
            bound      = longint'(threshold) * longint'(pixel_count);
            if (scaled_sum < bound) begin
                if (!run_open) begin
                    run_open  = 1'b1;
                    run_first = frame_index;
                end
                run_last = frame_index;
            end else if (run_open) begin
                close_run();
            end
            luma_sum    = '0;
            pixel_count = '0;
            if (frame_index != '1)
                frame_index = frame_index + 1'b1;
        endfunction

        task report_mismatch(string what);
            if (mismatches < 30)
                $display("[%0t] mismatch: %s", $time, what);
            mismatches++;
        endtask

        task check_result(logic [47:0] data);
            run_t want;
            runs_seen++;
            if (expected_runs.size() == 0) begin
                report_mismatch($sformatf("unexpected run %0d..%0d", data[23:0], data[47:24]));
                return;
            end
            want = expected_runs.pop_front();
            if (data[23:0] !== want.start_frame)
                report_mismatch($sformatf("start_frame %0d, want %0d",
                                          data[23:0], want.start_frame));
            if (data[47:24] !== want.end_frame)
                report_mismatch($sformatf("end_frame %0d, want %0d",
                                          data[47:24], want.end_frame));
        endtask
    endclass

    run_scoreboard sb = new();

    black_frame_run_detector DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always #CLK_HALF aclk = ~aclk;

    function automatic bit take_break();
        return !steady && ($urandom_range(99) < IDLE_PCT);
    endfunction

    // Result side: random backpressure, sampled handshakes go to the checker.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata);
        m_tready <= aresetn && !take_break();
    end

    // Input side monitor: every accepted item updates the prediction.
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready)
            sb.note_input(bfrd_pkg::cmd_t'(s_tuser[0]), s_tdata[7:0], s_tdata[15:8],
                          s_tdata[23:16], s_tlast);
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d runs still expected",
                     cycle_count, sb.pending());
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Presents one item and holds it until the handshake; valid stays up between
    // back-to-back items so there's only one assignment per edge.
    task automatic send_item(input bfrd_pkg::cmd_t cmd, input logic [7:0] b,
                             input logic [7:0] g, input logic [7:0] r, input logic last);
        while (take_break()) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {r, g, b};
        s_tuser  <= cmd;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic gray(input logic [7:0] level, input logic last);
        send_item(bfrd_pkg::CMD_PIXEL, level, level, level, last);
    endtask

    task automatic flush_video();
        send_item(bfrd_pkg::CMD_FLUSH, 8'($urandom), 8'($urandom), 8'($urandom),
                  1'($urandom_range(1)));
    endtask

    // Bring the block to idle: all predicted runs out, then let the pipe empty
    // since frames that close no run leave nothing to wait for.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_threshold(input logic [bfrd_pkg::THR_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        sb.set_threshold(value);
        threshold_writes++;
    endtask

    // Random video: short frames, half of them dark enough to land near the
    // threshold, with flushes between frames and now and then mid-frame.
    task automatic random_video(input int n_items);
        int          sent;
        int          size;
        bit          dark;
        int unsigned top;
        logic [7:0]  b, g, r;
        sent = 0;
        top  = (sb.threshold >> 7) + 1;
        if (top > 255)
            top = 255;
        while (sent < n_items) begin
            if ($urandom_range(99) < 4) begin
                flush_video();
                sent++;
            end else begin
                size = ($urandom_range(99) < 6) ? int'($urandom_range(20, 64))
                                                : int'($urandom_range(1, 6));
                dark = 1'($urandom_range(1));
                for (int i = 0; i < size; i++) begin
                    if ($urandom_range(99) < 2) begin
                        flush_video();      // broken frame, never finished
                        sent++;
                        break;
                    end
                    b = dark ? 8'($urandom_range(top)) : 8'($urandom_range(255));
                    g = dark ? 8'($urandom_range(top)) : 8'($urandom_range(255));
                    r = dark ? 8'($urandom_range(top)) : 8'($urandom_range(255));
                    send_item(bfrd_pkg::CMD_PIXEL, b, g, r, i == size - 1);
                    sent++;
                end
            end
        end
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed, reset threshold 5.0
        gray(8'd4, 1'b1);                   // frame 0 black
        gray(8'd5, 1'b1);                   // mean exactly 5: not black, closes 0..0
        gray(8'd0, 1'b1);                   // frame 2 black
        gray(8'd255, 1'b0);
        gray(8'd0, 1'b1);                   // mean 127.5, closes 2..2
        gray(8'd0, 1'b1);                   // frame 4 black
        send_item(bfrd_pkg::CMD_PIXEL, 8'd1, 8'd2, 8'd3, 1'b1);   // frame 5 black
        flush_video();                      // emits 4..5, index back to 0
        flush_video();                      // nothing open: no result
        gray(8'd255, 1'b0);                 // partial frame, discarded by the flush
        send_item(bfrd_pkg::CMD_FLUSH, 8'd255, 8'd255, 8'd255, 1'b1);
        gray(8'd0, 1'b1);                   // frame 0 black again
        gray(8'd4, 1'b0);
        gray(8'd6, 1'b1);                   // averages to exactly 5: closes 0..0
        gray(8'd4, 1'b0);
        gray(8'd5, 1'b1);                   // mean 4.5: black, frame 2
        send_item(bfrd_pkg::CMD_PIXEL, 8'd255, 8'd0, 8'd0, 1'b1); // blue only, luma 29
        send_item(bfrd_pkg::CMD_PIXEL, 8'd0, 8'd0, 8'd255, 1'b0);
        send_item(bfrd_pkg::CMD_PIXEL, 8'd0, 8'd255, 8'd0, 1'b1);
        gray(8'd3, 1'b1);
        flush_video();
        random_video(300);
        settle();

        write_threshold(16'd0);             // nothing is ever black
        random_video(100);
        settle();

        write_threshold(16'hFFFF);          // every frame is black
        random_video(100);
        flush_video();
        settle();

        write_threshold(16'd1280);
        steady = 1'b1;                      // full-rate stretch on both sides
        random_video(150);
        steady = 1'b0;
        settle();

        write_threshold(16'($urandom_range(65535)));
        random_video(200);
        settle();

        write_threshold(16'($urandom_range(1, 20) << 8));
        random_video(180);
        flush_video();
        settle();

        $display("Covered %0d input items and %0d closed runs over %0d threshold writes",
                 sb.items_seen, sb.runs_seen, threshold_writes);
        $display("Mismatches: %0d, cycles: %0d", sb.mismatches, cycle_count);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

### filelist.f
hdl/bfrd_pkg.sv
hdl/bfrd_frame_stats.sv
hdl/black_frame_run_detector.sv
tb/sv/black_frame_run_detector_test.sv
